// ===== rtl/swpc_pkg.sv =====
package swpc_pkg;

	localparam int MAX_FRAME_SYMBOLS = 65536;
	localparam int CNT_W = $clog2(MAX_FRAME_SYMBOLS + 1);
	localparam int WIN_W = 64;
	localparam int SCORE_W = 7;
	localparam int OFF_W = 16;
	localparam int NPAT = 8;
	localparam int PAT_W = $clog2(NPAT);
	localparam int LIMIT_W = 7;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [63:0] SYNC_WORD_RESET = 64'hFCA2B63DB00D9794;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd55;
	localparam logic [63:0] PAIR_LO = 64'h5555555555555555;
	localparam logic [63:0] PAIR_HI = 64'hAAAAAAAAAAAAAAAA;

	localparam logic REG_SYNC_WORD = 1'b0;
	localparam logic REG_DETECT_LIMIT = 1'b1;

	typedef struct packed {
		logic sym_bit;
		logic last;
	} swpc_item_t;

	function automatic logic [63:0] pair_swap(input logic [63:0] w);
		return ((w & PAIR_LO) << 1) | ((w & PAIR_HI) >> 1);
	endfunction

	function automatic logic [63:0] phase_rotate(input logic [63:0] w, input logic [1:0] q);
		logic [63:0] r;
		r = w;
		if (q[0]) begin
			r = ((~r & PAIR_LO) << 1) | ((r & PAIR_HI) >> 1);
		end
		if (q[1]) begin
			r = ~r;
		end
		return r;
	endfunction

	function automatic logic [63:0] pattern_of(input logic [63:0] sw, input logic [PAT_W-1:0] k);
		logic [63:0] base;
		base = k[2] ? pair_swap(sw) : sw;
		return phase_rotate(base, k[1:0]);
	endfunction

	function automatic logic [SCORE_W-1:0] ones64(input logic [63:0] w);
		logic [SCORE_W-1:0] c;
		c = '0;
		for (int i = 0; i < 64; i++) begin
			c = c + SCORE_W'(w[i]);
		end
		return c;
	endfunction

endpackage

// ===== rtl/swpc_front.sv =====
module swpc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [7:0]     soft_symbol,
	input  logic                  frame_end,
	output logic                  push_valid,
	input  logic                  push_ready,
	output swpc_pkg::swpc_item_t  push_item
);
	import swpc_pkg::*;

	logic       item_v_q;
	swpc_item_t item_q;

	assign in_ready   = !item_v_q || push_ready;
	assign push_valid = item_v_q;
	assign push_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_q <= 1'b0;
		end else if (in_ready) begin
			item_v_q <= in_valid;
		end
	end

	// zero or positive slices to one
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q.sym_bit <= ~soft_symbol[7];
			item_q.last    <= frame_end;
		end
	end

endmodule

// ===== rtl/swpc_queue.sv =====
module swpc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  swpc_pkg::swpc_item_t  push_item,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output swpc_pkg::swpc_item_t  pop_item
);
	import swpc_pkg::*;

	swpc_item_t           mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != Q_CNT_W'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != Q_CNT_W'(Q_DEPTH)) |-> (Q_PTR_W'(wr_ptr_q - rd_ptr_q) == Q_PTR_W'(count_q)))
		else $error("queue pointers disagree with count");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a request");

endmodule

// ===== rtl/swpc_back.sv =====
module swpc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  swpc_pkg::swpc_item_t        pop_item,
	input  logic                        cfg_valid,
	input  logic                        cfg_index,
	input  logic [63:0]                 cfg_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [swpc_pkg::PAT_W-1:0]   pattern_index,
	output logic [swpc_pkg::OFF_W-1:0]   match_offset,
	output logic [swpc_pkg::SCORE_W-1:0] match_score,
	output logic                        early_hit
);
	import swpc_pkg::*;

	localparam int WIDE_W = CNT_W + OFF_W;
	localparam logic [WIDE_W-1:0] OFF_MAX = WIDE_W'(2 ** OFF_W - 1);

	logic [63:0]          sync_word_q;
	logic [LIMIT_W-1:0]   limit_q;

	logic                 en;

	// window and symbol count
	logic [WIN_W-1:0]     window_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WIN_W-1:0]     window_nxt;
	logic [CNT_W-1:0]     diff;
	logic [WIDE_W-1:0]    diff_wide;
	logic [OFF_W-1:0]     off_nxt;

	logic                 valid_s1;
	logic                 last_s1;
	logic                 score_en_s1;
	logic [WIN_W-1:0]     window_s1;
	logic [OFF_W-1:0]     off_s1;

	logic                 valid_s2;
	logic                 last_s2;
	logic                 score_en_s2;
	logic [OFF_W-1:0]     off_s2;
	logic [SCORE_W-1:0]   score_s2 [NPAT];

	logic [SCORE_W-1:0]   best_score_q [NPAT];
	logic [OFF_W-1:0]     best_offset_q [NPAT];
	logic                 hit_done_q;

	logic [NPAT-1:0]      upd;
	logic                 hit_any;
	logic [PAT_W-1:0]     hit_k;
	logic [PAT_W-1:0]     pick;
	logic [SCORE_W-1:0]   top;
	logic                 res_v;
	logic [PAT_W-1:0]     res_idx;
	logic [OFF_W-1:0]     res_off;
	logic [SCORE_W-1:0]   res_score;
	logic                 res_early;

	logic                 out_v_q;
	logic [PAT_W-1:0]     idx_q;
	logic [OFF_W-1:0]     off_q;
	logic [SCORE_W-1:0]   score_q;
	logic                 early_q;

	assign en        = !out_v_q || out_ready;
	assign pop_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q <= SYNC_WORD_RESET;
			limit_q     <= LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SYNC_WORD:    sync_word_q <= cfg_data;
				REG_DETECT_LIMIT: limit_q     <= cfg_data[LIMIT_W-1:0];
				default:          ;
			endcase
		end
	end

	assign window_nxt = {window_q[WIN_W-2:0], pop_item.sym_bit};
	assign diff       = cnt_q - CNT_W'(WIN_W - 1);
	assign diff_wide  = WIDE_W'(diff);
	assign off_nxt    = (diff_wide > OFF_MAX) ? '1 : diff_wide[OFF_W-1:0];

	// stage a: window shift and offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pop_valid;
			if (pop_valid) begin
				if (pop_item.last) begin
					window_q <= '0;
					cnt_q    <= '0;
				end else begin
					window_q <= window_nxt;
					if (cnt_q != CNT_W'(MAX_FRAME_SYMBOLS)) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && pop_valid) begin
			last_s1     <= pop_item.last;
			score_en_s1 <= !pop_item.last && (cnt_q >= CNT_W'(WIN_W - 1));
			window_s1   <= window_nxt;
			off_s1      <= off_nxt;
		end
	end

	// stage b: match counts for all patterns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			last_s2     <= last_s1;
			score_en_s2 <= score_en_s1;
			off_s2      <= off_s1;
			for (int k = 0; k < NPAT; k++) begin
				score_s2[k] <= ones64(~(window_s1 ^ pattern_of(sync_word_q, PAT_W'(k))));
			end
		end
	end

	// stage c: best tracking and decision
	always_comb begin
		hit_any = 1'b0;
		hit_k   = '0;
		for (int k = 0; k < NPAT; k++) begin
			upd[k] = score_s2[k] > best_score_q[k];
			if (upd[k] && (score_s2[k] > limit_q) && !hit_any) begin
				hit_any = 1'b1;
				hit_k   = PAT_W'(k);
			end
		end
		pick = '0;
		top  = best_score_q[0];
		for (int k = 1; k < NPAT; k++) begin
			if (best_score_q[k] > top) begin
				top  = best_score_q[k];
				pick = PAT_W'(k);
			end
		end
		res_v     = 1'b0;
		res_idx   = pick;
		res_off   = best_offset_q[pick];
		res_score = top;
		res_early = 1'b0;
		if (valid_s2 && !hit_done_q) begin
			if (last_s2) begin
				res_v = 1'b1;
			end else if (score_en_s2 && hit_any) begin
				res_v     = 1'b1;
				res_idx   = hit_k;
				res_off   = off_s2;
				res_score = score_s2[hit_k];
				res_early = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_done_q <= 1'b0;
			for (int k = 0; k < NPAT; k++) begin
				best_score_q[k]  <= '0;
				best_offset_q[k] <= '0;
			end
		end else if (en && valid_s2) begin
			if (last_s2) begin
				hit_done_q <= 1'b0;
				for (int k = 0; k < NPAT; k++) begin
					best_score_q[k]  <= '0;
					best_offset_q[k] <= '0;
				end
			end else if (score_en_s2 && !hit_done_q) begin
				for (int k = 0; k < NPAT; k++) begin
					if (upd[k]) begin
						best_score_q[k]  <= score_s2[k];
						best_offset_q[k] <= off_s2;
					end
				end
				if (hit_any) begin
					hit_done_q <= 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en && res_v) begin
			idx_q   <= res_idx;
			off_q   <= res_off;
			score_q <= res_score;
			early_q <= res_early;
		end
	end

	assign out_valid     = out_v_q;
	assign pattern_index = idx_q;
	assign match_offset  = off_q;
	assign match_score   = score_q;
	assign early_hit     = early_q;

	a_hit_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		(en && res_v && res_early) |=> hit_done_q)
		else $error("early hit did not block the rest of the frame");

	a_no_result_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		hit_done_q |-> !res_v)
		else $error("result produced after early hit");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s2 && last_s2) |=> (!hit_done_q && best_score_q[0] == '0))
		else $error("frame end did not clear best scores");

	a_early_above_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && early_q) |-> (score_q > limit_q))
		else $error("early result not above limit");

endmodule

// ===== rtl/sync_word_phase_correlator_core.sv =====
// channel  direction  request fields                               handshake
// in       input      soft_symbol, frame_end                        in_valid / in_ready
// out      output     pattern_index, match_offset, match_score,     out_valid / out_ready
//                     early_hit
// cfg      input      cfg_index, cfg_data                           cfg_valid / cfg_ready
//
// one symbol per cycle unless the queue is full; a result passes through the front
// register, queue write, window stage, match count stage and result register
// eight 64-bit match counts are done in one stage, best scores kept in flops
// a result waiting at out stalls the back pipeline; the 4-entry queue keeps
// taking symbols until it fills
// arst_n clears all frame state; sync_word and detect_limit return to defaults
module sync_word_phase_correlator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [7:0]           soft_symbol,
	input  logic                        frame_end,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [swpc_pkg::PAT_W-1:0]   pattern_index,
	output logic [swpc_pkg::OFF_W-1:0]   match_offset,
	output logic [swpc_pkg::SCORE_W-1:0] match_score,
	output logic                        early_hit,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [63:0]                 cfg_data
);
	import swpc_pkg::*;

	logic       push_valid;
	logic       push_ready;
	swpc_item_t push_item;
	logic       pop_valid;
	logic       pop_ready;
	swpc_item_t pop_item;

	assign cfg_ready = 1'b1;

	swpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.soft_symbol(soft_symbol),
		.frame_end  (frame_end),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	swpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	swpc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pattern_index(pattern_index),
		.match_offset (match_offset),
		.match_score  (match_score),
		.early_hit    (early_hit)
	);

endmodule
